### design/bbu_pkg.sv
// Shared types and constants for the RGB background blend unit.
// No dependencies; used by the interfaces, the lane and the top level.
package bbu_pkg;

   localparam int unsigned ChanWidth = 8;
   localparam int unsigned KindWidth = 4;
   localparam int unsigned NumLanes  = 3;
   localparam int unsigned DivStages = 4;

   localparam logic [ChanWidth-1:0] ChanMax     = 8'd255;
   localparam logic [ChanWidth-1:0] OverlayKnee = 8'd128;
   localparam logic [15:0]          Recip255    = 16'd32897;

   typedef enum logic [KindWidth-1:0] {
      BBU_KEEP     = 4'd0,
      BBU_SET      = 4'd1,
      BBU_MULTIPLY = 4'd2,
      BBU_LIGHTEN  = 4'd3,
      BBU_DARKEN   = 4'd4,
      BBU_SCREEN   = 4'd5,
      BBU_DODGE    = 4'd6,
      BBU_CBURN    = 4'd7,
      BBU_ADD      = 4'd8,
      BBU_ALPHAADD = 4'd9,
      BBU_LBURN    = 4'd10,
      BBU_OVERLAY  = 4'd11,
      BBU_LERP     = 4'd12
   } bbu_kind_type;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [ChanWidth-1:0] old_val;
      logic [ChanWidth-1:0] new_val;
      logic [15:0]          prod;
      logic                 dbl;
      logic                 neg;
      logic [8:0]           q255;
      logic [ChanWidth-1:0] den;
      logic [ChanWidth-1:0] rem;
      logic [ChanWidth-1:0] low;
      logic [ChanWidth-1:0] dq;
      logic                 ovf;
   } bbu_stage_type;

endpackage

### design/bbu_if.sv
// Valid/ready channel interfaces for blend requests and blended results.
// Depends on bbu_pkg for the channel width.
interface bbu_req_if import bbu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ChanWidth-1:0] old_red;
   logic [ChanWidth-1:0] old_green;
   logic [ChanWidth-1:0] old_blue;
   logic [ChanWidth-1:0] new_red;
   logic [ChanWidth-1:0] new_green;
   logic [ChanWidth-1:0] new_blue;
   logic [KindWidth-1:0] kind;
   logic [ChanWidth-1:0] alpha;

   modport source (output valid, old_red, old_green, old_blue, new_red, new_green,
                   new_blue, kind, alpha, input ready);
   modport sink   (input valid, old_red, old_green, old_blue, new_red, new_green,
                   new_blue, kind, alpha, output ready);
endinterface

interface bbu_rsp_if import bbu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ChanWidth-1:0] out_red;
   logic [ChanWidth-1:0] out_green;
   logic [ChanWidth-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

### design/rgb_background_blend_unit_core.sv
// Blends an incoming RGB color onto a background color under one of thirteen
// layer modes, one item per clock while the output is not stalled. Three
// channel lanes (bbu_lane) run side by side through a five-register pipeline
// whose length is set by the 8-step divider for dodge and color burn (two
// steps per divider register); a shared output register merges the three lane
// results into one item and drives rsp_chan. The whole pipeline holds while a
// result waits on a low ready. No reset clearing pass is needed.
// Uses bbu_pkg, bbu_req_if, bbu_rsp_if and bbu_lane.
module rgb_background_blend_unit_core import bbu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bbu_req_if.sink     req_chan,
   bbu_rsp_if.source   rsp_chan
);

   logic [DivStages:0]   vld_ff, vld_in;
   logic                 out_vld_ff, out_vld_in;
   logic [ChanWidth-1:0] lane_res [NumLanes];
   logic [ChanWidth-1:0] red_ff, green_ff, blue_ff;
   logic                 en;

   assign en             = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   bbu_lane u_lane_red (
      .clock(clock), .en(en), .kind(req_chan.kind), .alpha(req_chan.alpha),
      .old_val(req_chan.old_red), .new_val(req_chan.new_red), .result(lane_res[0])
   );
   bbu_lane u_lane_green (
      .clock(clock), .en(en), .kind(req_chan.kind), .alpha(req_chan.alpha),
      .old_val(req_chan.old_green), .new_val(req_chan.new_green), .result(lane_res[1])
   );
   bbu_lane u_lane_blue (
      .clock(clock), .en(en), .kind(req_chan.kind), .alpha(req_chan.alpha),
      .old_val(req_chan.old_blue), .new_val(req_chan.new_blue), .result(lane_res[2])
   );

   assign vld_in     = {vld_ff[DivStages-1:0], req_chan.valid};
   assign out_vld_in = vld_ff[DivStages];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff   <= lane_res[0];
         green_ff <= lane_res[1];
         blue_ff  <= lane_res[2];
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.out_red   = red_ff;
   assign rsp_chan.out_green = green_ff;
   assign rsp_chan.out_blue  = blue_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (vld_ff == '0 && !out_vld_ff))
      else $error("pipeline valids not cleared by reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted item missing from first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(vld_ff) && $stable(red_ff) && out_vld_ff))
      else $error("pipeline moved during output stall");

   a_drain_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[DivStages]) |=> out_vld_ff)
      else $error("last stage item lost before output register");

endmodule

### design/bbu_lane.sv
// One color channel of the blend unit: operand select, multiply, divide by 255,
// pipelined 8-step divider for dodge and color burn, final combine. Uses bbu_pkg.
module bbu_lane import bbu_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [KindWidth-1:0] kind,
   input  logic [ChanWidth-1:0] alpha,
   input  logic [ChanWidth-1:0] old_val,
   input  logic [ChanWidth-1:0] new_val,
   output logic [ChanWidth-1:0] result
);

   bbu_stage_type st_ff [DivStages+1];
   bbu_stage_type st_in [DivStages+1];

   function automatic bbu_stage_type div_step(input bbu_stage_type s);
      logic [8:0]    t;
      bbu_stage_type r;
      r = s;
      t = {s.rem, s.low[ChanWidth-1]};
      r.low = {s.low[ChanWidth-2:0], 1'b0};
      if (t >= {1'b0, s.den}) begin
         r.rem = ChanWidth'(t - {1'b0, s.den});
         r.dq  = {s.dq[ChanWidth-2:0], 1'b1};
      end else begin
         r.rem = t[ChanWidth-1:0];
         r.dq  = {s.dq[ChanWidth-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      logic [ChanWidth-1:0] mx, my, d, io, in_n;
      logic [15:0]          num;
      logic                 dbl, neg;
      io   = ChanMax - old_val;
      in_n = ChanMax - new_val;
      mx = '0; my = '0; dbl = 1'b0; neg = 1'b0; num = '0; d = '0;
      unique case (kind)
         BBU_MULTIPLY: begin mx = old_val; my = new_val; end
         BBU_SCREEN:   begin mx = io; my = in_n; end
         BBU_ALPHAADD: begin mx = alpha; my = new_val; end
         BBU_OVERLAY: begin
            dbl = 1'b1;
            if (new_val <= OverlayKnee) begin
               mx = new_val; my = old_val;
            end else begin
               mx = in_n; my = io;
            end
         end
         BBU_LERP: begin
            neg = new_val < old_val;
            mx  = neg ? old_val - new_val : new_val - old_val;
            my  = alpha;
         end
         BBU_DODGE: begin
            num = {new_val, 8'h00} - {8'h00, new_val};
            d   = io;
         end
         BBU_CBURN: begin
            num = {io, 8'h00} - {8'h00, io};
            d   = new_val;
         end
         default: begin end
      endcase
      st_in[0].kind    = kind;
      st_in[0].old_val = old_val;
      st_in[0].new_val = new_val;
      st_in[0].prod    = {8'h00, mx} * {8'h00, my};
      st_in[0].dbl     = dbl;
      st_in[0].neg     = neg;
      st_in[0].q255    = '0;
      st_in[0].den     = d;
      st_in[0].rem     = num[15:8];
      st_in[0].low     = num[7:0];
      st_in[0].dq      = '0;
      st_in[0].ovf     = num >= {d, 8'h00};
   end

   for (genvar k = 1; k <= DivStages; k++) begin : g_stage
      always_comb begin
         logic [16:0] n17;
         logic [32:0] t;
         st_in[k] = div_step(div_step(st_ff[k-1]));
         n17 = st_ff[k-1].dbl ? {st_ff[k-1].prod, 1'b0} : {1'b0, st_ff[k-1].prod};
         t   = {16'h0000, n17} * {17'h00000, Recip255};
         if (k == 1) begin
            st_in[k].q255 = t[31:23];
         end
      end
   end

   for (genvar k = 0; k <= DivStages; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      bbu_stage_type s;
      logic signed [10:0] o, n, q, dq, r;
      s  = st_ff[DivStages];
      o  = 11'(s.old_val);
      n  = 11'(s.new_val);
      q  = 11'(s.q255);
      dq = 11'(s.dq);
      unique case (s.kind)
         BBU_SET:      r = n;
         BBU_MULTIPLY: r = q;
         BBU_LIGHTEN:  r = (o > n) ? o : n;
         BBU_DARKEN:   r = (o < n) ? o : n;
         BBU_SCREEN:   r = 11'sd255 - q;
         BBU_DODGE:    r = s.ovf ? 11'sd255 : dq;
         BBU_CBURN:    r = s.ovf ? 11'sd0 : 11'sd255 - dq;
         BBU_ADD:      r = o + n;
         BBU_ALPHAADD: r = o + q;
         BBU_LBURN:    r = o + n - 11'sd255;
         BBU_OVERLAY:  r = (s.new_val <= OverlayKnee) ? q : 11'sd255 - q;
         BBU_LERP:     r = s.neg ? o - q : o + q;
         default:      r = o;
      endcase
      if (r < 0) begin
         result = '0;
      end else if (r > 11'sd255) begin
         result = ChanMax;
      end else begin
         result = r[ChanWidth-1:0];
      end
   end

endmodule

### bench/rgb_background_blend_unit_core_test.sv
// Self-checking bench for rgb_background_blend_unit_core: a directed table of blend
// items, then random items, each result checked against a table color or predictor.
// Depends on bbu_pkg, bbu_req_if, bbu_rsp_if and the core.
`timescale 1ns / 100ps

module rgb_background_blend_unit_core_test;
   import bbu_pkg::*;

   typedef struct packed {
      logic [7:0] ored, ogrn, oblu, nred, ngrn, nblu;
      logic [3:0] kind;
      logic [7:0] alpha;
   } blend_item_type;

   typedef struct packed {
      logic [7:0] r, g, b;
   } color_type;

   typedef struct packed {
      blend_item_type item;
      logic           typed;
      color_type      color;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bbu_req_if req_chan ();
   bbu_rsp_if rsp_chan ();

   rgb_background_blend_unit_core uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   color_type     blended_q[$];
   int            fail_count = 0;
   bit            send_done  = 1'b0;
   bit            hold_rsp   = 1'b0;
   int            idle_cycles = 0;
   table_row_type rows[$];

   function automatic logic [7:0] blend_chan(logic [3:0] kind, logic [7:0] ov, logic [7:0] nv,
                                            logic [7:0] av);
      int o, n, a, r;
      o = ov; n = nv; a = av;
      case (kind)
         BBU_SET:      r = n;
         BBU_MULTIPLY: r = o * n / 255;
         BBU_LIGHTEN:  r = (o > n) ? o : n;
         BBU_DARKEN:   r = (o < n) ? o : n;
         BBU_SCREEN:   r = 255 - (255 - o) * (255 - n) / 255;
         BBU_DODGE:    r = (o == 255) ? 255 : (255 * n) / (255 - o);
         BBU_CBURN:    r = (n == 0) ? 0 : 255 - (255 * (255 - o)) / n;
         BBU_ADD:      r = o + n;
         BBU_ALPHAADD: r = o + a * n / 255;
         BBU_LBURN:    r = o + n - 255;
         BBU_OVERLAY:  r = (n <= 128) ? (2 * n * o / 255)
                                      : (255 - 2 * (255 - n) * (255 - o) / 255);
         BBU_LERP:     r = o + ((n - o) * a) / 255;
         default:      r = o;
      endcase
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      return r[7:0];
   endfunction

   function automatic color_type blend_color(blend_item_type it);
      color_type c;
      c.r = blend_chan(it.kind, it.ored, it.nred, it.alpha);
      c.g = blend_chan(it.kind, it.ogrn, it.ngrn, it.alpha);
      c.b = blend_chan(it.kind, it.oblu, it.nblu, it.alpha);
      return c;
   endfunction

   function automatic blend_item_type random_item();
      blend_item_type it;
      it = 60'({$urandom, $urandom});
      case ($urandom_range(0, 5))
         0: begin
            it.ored = 8'hff; it.nblu = 8'h00;
         end
         1: begin
            it.nred = 8'd128; it.ngrn = 8'd129; it.oblu = 8'hff;
         end
         default: ;
      endcase
      return it;
   endfunction

   function automatic table_row_type mk(blend_item_type it, bit typed, color_type c);
      table_row_type row;
      row.item = it; row.typed = typed; row.color = c;
      return row;
   endfunction

   function automatic int gap_len();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      return n;
   endfunction

   task automatic send_item(blend_item_type it);
      req_chan.valid     <= 1'b1;
      req_chan.old_red   <= it.ored;
      req_chan.old_green <= it.ogrn;
      req_chan.old_blue  <= it.oblu;
      req_chan.new_red   <= it.nred;
      req_chan.new_green <= it.ngrn;
      req_chan.new_blue  <= it.nblu;
      req_chan.kind      <= it.kind;
      req_chan.alpha     <= it.alpha;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic push_item(blend_item_type it, bit typed, color_type c);
      color_type p;
      int        n;
      p = blend_color(it);
      blended_q.push_back(typed ? c : p);
      send_item(it);
      n = ($urandom_range(0, 2) != 0) ? gap_len() : 0;
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      {req_chan.old_red, req_chan.old_green, req_chan.old_blue} <= '0;
      {req_chan.new_red, req_chan.new_green, req_chan.new_blue} <= '0;
      req_chan.kind  <= BBU_KEEP;
      req_chan.alpha <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      rows.push_back(mk({8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, BBU_KEEP, 8'hff}, 1,
                        {8'd10, 8'd20, 8'd30}));
      rows.push_back(mk({8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, BBU_SET, 8'h00}, 1,
                        {8'd40, 8'd50, 8'd60}));
      rows.push_back(mk({8'hff, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, BBU_MULTIPLY, 8'h00}, 1,
                        {8'hff, 8'h00, 8'h00}));
      rows.push_back(mk({8'h00, 8'hff, 8'h80, 8'hff, 8'h00, 8'h7f, BBU_LIGHTEN, 8'h00}, 0, '0));
      rows.push_back(mk({8'h00, 8'hff, 8'h80, 8'hff, 8'h00, 8'h7f, BBU_DARKEN, 8'h00}, 0, '0));
      rows.push_back(mk({8'h00, 8'hff, 8'h40, 8'h00, 8'h00, 8'h90, BBU_SCREEN, 8'h00}, 0, '0));
      rows.push_back(mk({8'hff, 8'hfe, 8'h00, 8'h00, 8'hff, 8'h80, BBU_DODGE, 8'h00}, 1,
                        {8'hff, 8'hff, 8'h80}));
      rows.push_back(mk({8'h00, 8'h00, 8'hff, 8'h00, 8'h01, 8'hff, BBU_CBURN, 8'h00}, 1,
                        {8'h00, 8'h00, 8'hff}));
      rows.push_back(mk({8'hff, 8'h00, 8'h80, 8'hff, 8'h00, 8'h80, BBU_ADD, 8'h00}, 1,
                        {8'hff, 8'h00, 8'hff}));
      rows.push_back(mk({8'h10, 8'hf0, 8'h00, 8'hff, 8'hff, 8'h80, BBU_ALPHAADD, 8'hff}, 0, '0));
      rows.push_back(mk({8'h10, 8'hf0, 8'h00, 8'hff, 8'hff, 8'h80, BBU_ALPHAADD, 8'h00}, 1,
                        {8'h10, 8'hf0, 8'h00}));
      rows.push_back(mk({8'h00, 8'hff, 8'h80, 8'h00, 8'hff, 8'h80, BBU_LBURN, 8'h00}, 1,
                        {8'h00, 8'hff, 8'h01}));
      rows.push_back(mk({8'hff, 8'hff, 8'h00, 8'd128, 8'd129, 8'hff, BBU_OVERLAY, 8'h00}, 1,
                        {8'hff, 8'hff, 8'hff}));
      rows.push_back(mk({8'h00, 8'hff, 8'h64, 8'hff, 8'h00, 8'h10, BBU_LERP, 8'hff}, 1,
                        {8'hff, 8'h00, 8'h10}));
      rows.push_back(mk({8'h00, 8'hff, 8'h64, 8'hff, 8'h00, 8'h10, BBU_LERP, 8'h00}, 1,
                        {8'h00, 8'hff, 8'h64}));
      rows.push_back(mk({8'h05, 8'hff, 8'h64, 8'hfa, 8'h00, 8'h10, BBU_LERP, 8'h80}, 0, '0));
      rows.push_back(mk({8'h01, 8'h02, 8'h03, 8'hff, 8'hff, 8'hff, 4'd13, 8'hff}, 1,
                        {8'h01, 8'h02, 8'h03}));
      rows.push_back(mk({8'h01, 8'h02, 8'h03, 8'hff, 8'hff, 8'hff, 4'd14, 8'hff}, 1,
                        {8'h01, 8'h02, 8'h03}));
      rows.push_back(mk({8'hfe, 8'h7f, 8'h80, 8'h01, 8'h55, 8'haa, 4'd15, 8'haa}, 1,
                        {8'hfe, 8'h7f, 8'h80}));
      foreach (rows[i]) push_item(rows[i].item, rows[i].typed, rows[i].color);
      fork
         begin
            repeat (3) @(posedge clock);
            hold_rsp = 1'b1;
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (int i = 0; i < 40; i++) push_item(random_item(), 0, '0);
         end
      join
      for (int i = 0; i < 810; i++) push_item(random_item(), 0, '0);
      req_chan.valid <= 1'b0;
      send_done = 1'b1;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_chan.ready <= 1'b0;
         else if ($urandom_range(0, 3) == 0)
            rsp_chan.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
         else rsp_chan.ready <= ($urandom_range(0, 4) != 0);
      end
   end

   always @(posedge clock) begin
      color_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (blended_q.size() == 0) begin
            $error("result with nothing expected: %h %h %h", rsp_chan.out_red,
                   rsp_chan.out_green, rsp_chan.out_blue);
            fail_count++;
         end else begin
            want = blended_q.pop_front();
            if (rsp_chan.out_red !== want.r) begin
               $error("out_red expected %0d actual %0d", want.r, rsp_chan.out_red);
               fail_count++;
            end
            if (rsp_chan.out_green !== want.g) begin
               $error("out_green expected %0d actual %0d", want.g, rsp_chan.out_green);
               fail_count++;
            end
            if (rsp_chan.out_blue !== want.b) begin
               $error("out_blue expected %0d actual %0d", want.b, rsp_chan.out_blue);
               fail_count++;
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      while (!(send_done && blended_q.size() == 0)) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= 2000) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && blended_q.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
